// ----- hdl/lzjb_pkg.sv -----
// Shared constants, command kinds and result status codes for the LZJB decompressor.
`default_nettype none

package lzjb_pkg;

   localparam int HISTORY_DEPTH   = 1024;
   localparam int MATCH_LEN_BITS  = 6;
   localparam int MIN_MATCH       = 3;
   localparam int CMD_QUEUE_DEPTH = 4;

   localparam int          LENGTH_W         = 18;
   localparam logic [17:0] OUT_LENGTH_RESET = 18'd512;
   localparam logic [3:0]  CTRL_SLOTS       = 4'd8;
   localparam int          RSP_DATA_W       = 24;

   typedef enum logic [1:0] {
      CMD_LITERAL = 2'd0,
      CMD_MATCH   = 2'd1,
      CMD_ERROR   = 2'd2
   } cmd_kind_type;

   typedef enum logic [1:0] {
      STATUS_DATA  = 2'd0,
      STATUS_ERROR = 2'd1,
      STATUS_DONE  = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/lzjb_front.sv -----
// Token parser that classifies compressed bytes and issues copy commands.
`default_nettype none

module lzjb_front #(
   parameter int HISTORY_DEPTH  = lzjb_pkg::HISTORY_DEPTH,
   parameter int MATCH_LEN_BITS = lzjb_pkg::MATCH_LEN_BITS,
   parameter int MIN_MATCH      = lzjb_pkg::MIN_MATCH,
   localparam int AW    = $clog2(HISTORY_DEPTH),
   localparam int LEN_W = MATCH_LEN_BITS + 1,
   localparam int CMD_W = 2 + 8 + LEN_W + 2 * AW + 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,
   input  wire logic             req_tuser,
   input  wire logic             csr_we,
   input  wire logic [17:0]      csr_wdata,
   input  wire logic             cmd_full,
   output logic                  cmd_push,
   output logic [CMD_W-1:0]      cmd_data
);

   localparam int LW    = lzjb_pkg::LENGTH_W;
   localparam int OFF_W = 16 - MATCH_LEN_BITS;
   localparam int PW    = AW + 1;
   localparam int SW    = ((PW > LEN_W) ? PW : LEN_W) + 1;

   typedef struct packed {
      lzjb_pkg::cmd_kind_type kind;
      logic [7:0]             lit;
      logic [LEN_W-1:0]       count;
      logic [AW-1:0]          dest;
      logic [AW-1:0]          src;
      logic                   blk_done;
   } cmd_type;

   logic [LW-1:0]  out_len_ff, out_len_in;
   logic [7:0]     ctrl_bits_ff, ctrl_bits_in;
   logic [3:0]     ctrl_pos_ff, ctrl_pos_in;
   logic [7:0]     match_high_ff, match_high_in;
   logic           await_ff, await_in;
   logic [LW-1:0]  produced_ff, produced_in;
   logic [AW-1:0]  wr_pos_ff, wr_pos_in;
   logic           halted_ff, halted_in;

   logic           accept;
   logic [7:0]     e_bits;
   logic [3:0]     e_pos;
   logic           e_await;
   logic [LW-1:0]  e_prod;
   logic [AW-1:0]  e_wr;
   logic           e_halt;
   logic [OFF_W-1:0] off;
   logic [LEN_W-1:0] len_v;
   logic [LEN_W-1:0] n_bytes;
   logic [LW-1:0]  remain;
   logic           done;
   logic           bad;
   logic [PW-1:0]  off_p;
   logic [PW-1:0]  wr_p;
   logic [PW-1:0]  src_p;
   logic [SW-1:0]  wr_sum;
   cmd_type        cmd;

   assign req_tready = !cmd_full;
   assign accept     = req_tvalid && !cmd_full;
   assign cmd_data   = CMD_W'(cmd);

   always_comb begin
      e_bits  = req_tuser ? 8'd0 : ctrl_bits_ff;
      e_pos   = req_tuser ? lzjb_pkg::CTRL_SLOTS : ctrl_pos_ff;
      e_await = req_tuser ? 1'b0 : await_ff;
      e_prod  = req_tuser ? '0 : produced_ff;
      e_wr    = req_tuser ? '0 : wr_pos_ff;
      e_halt  = req_tuser ? 1'b0 : halted_ff;

      off    = OFF_W'({match_high_ff, req_tdata});
      len_v  = LEN_W'(match_high_ff[7 -: MATCH_LEN_BITS]) + LEN_W'(MIN_MATCH);
      remain = out_len_ff - e_prod;
      done   = remain <= LW'(len_v);
      n_bytes = done ? remain[LEN_W-1:0] : len_v;
      bad    = (off == '0) || (LW'(off) > e_prod) || (int'(off) > HISTORY_DEPTH);
      off_p  = PW'(off);
      wr_p   = PW'(e_wr);
      src_p  = (off_p > wr_p) ? (wr_p + PW'(HISTORY_DEPTH) - off_p) : (wr_p - off_p);
      wr_sum = SW'(e_wr) + SW'(n_bytes);
      if (wr_sum >= SW'(2 * HISTORY_DEPTH)) begin
         wr_sum = wr_sum - SW'(2 * HISTORY_DEPTH);
      end else if (wr_sum >= SW'(HISTORY_DEPTH)) begin
         wr_sum = wr_sum - SW'(HISTORY_DEPTH);
      end

      out_len_in    = csr_we ? csr_wdata : out_len_ff;
      ctrl_bits_in  = ctrl_bits_ff;
      ctrl_pos_in   = ctrl_pos_ff;
      match_high_in = match_high_ff;
      await_in      = await_ff;
      produced_in   = produced_ff;
      wr_pos_in     = wr_pos_ff;
      halted_in     = halted_ff;
      cmd_push      = 1'b0;
      cmd           = '0;
      cmd.kind      = lzjb_pkg::CMD_LITERAL;

      if (accept) begin
         ctrl_bits_in = e_bits;
         ctrl_pos_in  = e_pos;
         await_in     = e_await;
         produced_in  = e_prod;
         wr_pos_in    = e_wr;
         halted_in    = e_halt;
         if (!(e_halt || (e_prod >= out_len_ff))) begin
            if (e_await) begin
               await_in    = 1'b0;
               ctrl_pos_in = e_pos + 4'd1;
               cmd_push    = 1'b1;
               if (bad) begin
                  halted_in = 1'b1;
                  cmd.kind  = lzjb_pkg::CMD_ERROR;
               end else begin
                  cmd.kind     = lzjb_pkg::CMD_MATCH;
                  cmd.count    = n_bytes;
                  cmd.dest     = e_wr;
                  cmd.src      = src_p[AW-1:0];
                  cmd.blk_done = done;
                  produced_in  = e_prod + LW'(n_bytes);
                  wr_pos_in    = wr_sum[AW-1:0];
                  halted_in    = done;
               end
            end else if (e_pos >= lzjb_pkg::CTRL_SLOTS) begin
               ctrl_bits_in = req_tdata;
               ctrl_pos_in  = 4'd0;
            end else if (e_bits[e_pos[2:0]]) begin
               match_high_in = req_tdata;
               await_in      = 1'b1;
            end else begin
               ctrl_pos_in  = e_pos + 4'd1;
               cmd_push     = 1'b1;
               cmd.kind     = lzjb_pkg::CMD_LITERAL;
               cmd.lit      = req_tdata;
               cmd.count    = LEN_W'(1);
               cmd.dest     = e_wr;
               cmd.blk_done = (e_prod + LW'(1)) >= out_len_ff;
               produced_in  = e_prod + LW'(1);
               wr_pos_in    = (e_wr == AW'(HISTORY_DEPTH - 1)) ? '0 : e_wr + 1'b1;
               halted_in    = cmd.blk_done;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_len_ff    <= lzjb_pkg::OUT_LENGTH_RESET;
         ctrl_bits_ff  <= '0;
         ctrl_pos_ff   <= lzjb_pkg::CTRL_SLOTS;
         match_high_ff <= '0;
         await_ff      <= 1'b0;
         produced_ff   <= '0;
         wr_pos_ff     <= '0;
         halted_ff     <= 1'b0;
      end else begin
         out_len_ff    <= out_len_in;
         ctrl_bits_ff  <= ctrl_bits_in;
         ctrl_pos_ff   <= ctrl_pos_in;
         match_high_ff <= match_high_in;
         await_ff      <= await_in;
         produced_ff   <= produced_in;
         wr_pos_ff     <= wr_pos_in;
         halted_ff     <= halted_in;
      end
   end

   // A block halts only on a finished token, so it never waits for a second match byte.
   assert property (@(posedge clock) disable iff (reset) !(await_ff && halted_ff))
      else $error("front halted while a match is half read");

endmodule

`default_nettype wire

// ----- hdl/lzjb_cmd_fifo.sv -----
// Short command queue between the token parser and the copy engine.
`default_nettype none

module lzjb_cmd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = lzjb_pkg::CMD_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int QAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full     = cnt_ff == CW'(DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The parser holds off its input while the queue is full, so no command is dropped.
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("command pushed into a full queue");

endmodule

`default_nettype wire

// ----- hdl/lzjb_back.sv -----
// Copy engine that owns the history memory and emits result beats.
`default_nettype none

module lzjb_back #(
   parameter int HISTORY_DEPTH  = lzjb_pkg::HISTORY_DEPTH,
   parameter int MATCH_LEN_BITS = lzjb_pkg::MATCH_LEN_BITS,
   localparam int AW    = $clog2(HISTORY_DEPTH),
   localparam int LEN_W = MATCH_LEN_BITS + 1,
   localparam int CMD_W = 2 + 8 + LEN_W + 2 * AW + 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cmd_valid,
   input  wire logic [CMD_W-1:0]              cmd_data,
   output logic                               cmd_pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [lzjb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast
);

   typedef struct packed {
      lzjb_pkg::cmd_kind_type kind;
      logic [7:0]             lit;
      logic [LEN_W-1:0]       count;
      logic [AW-1:0]          dest;
      logic [AW-1:0]          src;
      logic                   blk_done;
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_COPY
   } state_type;

   function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
      return (a == AW'(HISTORY_DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   logic [7:0] history_ff [HISTORY_DEPTH];
   logic [7:0] q_ff;
   logic       byp_ff;
   logic [7:0] byp_data_ff;

   state_type           state_ff, state_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [LEN_W-1:0]    remain_ff, remain_in;
   logic                done_ff, done_in;
   logic                have_ff, have_in;
   logic [7:0]          pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_first_ff, rsp_first_in;
   logic [7:0]          rsp_second_ff, rsp_second_in;
   logic [1:0]          rsp_count_ff, rsp_count_in;
   lzjb_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   cmd_type       cmd;
   logic [7:0]    d;
   logic          slot_free;
   logic          last_byte;
   logic          need_out;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_count_ff, rsp_second_ff, rsp_first_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      cmd       = cmd_type'(cmd_data);
      d         = byp_ff ? byp_data_ff : q_ff;
      slot_free = !rsp_valid_ff || rsp_tready;
      last_byte = remain_ff == LEN_W'(1);
      need_out  = have_ff || last_byte;

      state_in      = state_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      remain_in     = remain_ff;
      done_in       = done_ff;
      have_in       = have_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = wr_ptr_ff;
      wr_data       = d;
      rd_en         = 1'b0;
      rd_addr       = rd_ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  lzjb_pkg::CMD_LITERAL: begin
                     if (slot_free) begin
                        cmd_pop       = 1'b1;
                        wr_en         = 1'b1;
                        wr_addr       = cmd.dest;
                        wr_data       = cmd.lit;
                        rsp_valid_in  = 1'b1;
                        rsp_first_in  = cmd.lit;
                        rsp_second_in = 8'd0;
                        rsp_count_in  = 2'd1;
                        rsp_status_in = cmd.blk_done ? lzjb_pkg::STATUS_DONE
                                                     : lzjb_pkg::STATUS_DATA;
                        rsp_last_in   = 1'b1;
                     end
                  end
                  lzjb_pkg::CMD_MATCH: begin
                     cmd_pop   = 1'b1;
                     rd_en     = 1'b1;
                     rd_addr   = cmd.src;
                     rd_ptr_in = next_addr(cmd.src);
                     wr_ptr_in = cmd.dest;
                     remain_in = cmd.count;
                     done_in   = cmd.blk_done;
                     have_in   = 1'b0;
                     state_in  = ST_COPY;
                  end
                  default: begin
                     if (slot_free) begin
                        cmd_pop       = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_first_in  = 8'd0;
                        rsp_second_in = 8'd0;
                        rsp_count_in  = 2'd0;
                        rsp_status_in = lzjb_pkg::STATUS_ERROR;
                        rsp_last_in   = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_COPY: begin
            if (!need_out || slot_free) begin
               wr_en     = 1'b1;
               wr_ptr_in = next_addr(wr_ptr_ff);
               remain_in = remain_ff - 1'b1;
               if (need_out) begin
                  rsp_valid_in  = 1'b1;
                  rsp_first_in  = have_ff ? pend_ff : d;
                  rsp_second_in = have_ff ? d : 8'd0;
                  rsp_count_in  = have_ff ? 2'd2 : 2'd1;
                  rsp_status_in = (done_ff && last_byte) ? lzjb_pkg::STATUS_DONE
                                                         : lzjb_pkg::STATUS_DATA;
                  rsp_last_in   = last_byte;
                  have_in       = 1'b0;
               end else begin
                  pend_in = d;
                  have_in = 1'b1;
               end
               if (last_byte) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  rd_ptr_in = next_addr(rd_ptr_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff      <= have_in;
         remain_ff    <= remain_in;
      end
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      done_ff       <= done_in;
      pend_ff       <= pend_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // A read of the entry written in the same cycle takes the new byte from the bypass.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         history_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff        <= history_ff[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (remain_ff != '0))
      else $error("copy running with no bytes left");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == lzjb_pkg::STATUS_ERROR))
         |-> ((rsp_count_ff == 2'd0) && rsp_last_ff))
      else $error("error beat carries data or is not the last of its run");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == lzjb_pkg::STATUS_DONE)) |-> rsp_last_ff)
      else $error("block complete on a beat that is not the last of its run");

endmodule

`default_nettype wire

// ----- hdl/lzjb_block_decompressor.sv -----
// Top level of the LZJB block decompressor: parser, command queue and copy engine.
//
//   Channel | Direction | Handshake             | Payload
//   req     | in        | req_tvalid/req_tready | tdata: data_byte; tuser: new_block
//   rsp     | out       | rsp_tvalid/rsp_tready | tdata: bytes and count; tuser: status
//   csr     | in        | csr_we                | csr_wdata: output_length
//
// The parser takes one input beat per cycle while the four-entry command queue has room.
// A literal leaves the copy engine straight from idle; a match first reads its source byte,
// then copies with one history memory read per byte and pairs the bytes into two-byte beats.
// Input stalls when the queue fills behind a long match or a stalled result channel.
// Reset clears the control state but not the history memory or the copy engine's pointers.
`default_nettype none

module lzjb_block_decompressor #(
   parameter int HISTORY_DEPTH  = lzjb_pkg::HISTORY_DEPTH,
   parameter int MATCH_LEN_BITS = lzjb_pkg::MATCH_LEN_BITS,
   parameter int MIN_MATCH      = lzjb_pkg::MIN_MATCH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,  // [7:0] data_byte
   input  wire logic                          req_tuser,  // [0] new_block
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [7:0] out_byte_first, [15:8] out_byte_second, [17:16] valid_count, zero above
   output logic [lzjb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [1:0]                         rsp_tuser,  // [1:0] status
   output logic                               rsp_tlast,
   input  wire logic                          csr_we,
   input  wire logic [17:0]                   csr_wdata
);

   localparam int AW    = $clog2(HISTORY_DEPTH);
   localparam int LEN_W = MATCH_LEN_BITS + 1;
   localparam int CMD_W = 2 + 8 + LEN_W + 2 * AW + 1;

   logic             q_full;
   logic             q_push;
   logic [CMD_W-1:0] q_push_data;
   logic             q_empty;
   logic             q_pop;
   logic [CMD_W-1:0] q_pop_data;

   lzjb_front #(
      .HISTORY_DEPTH  (HISTORY_DEPTH),
      .MATCH_LEN_BITS (MATCH_LEN_BITS),
      .MIN_MATCH      (MIN_MATCH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd_full   (q_full),
      .cmd_push   (q_push),
      .cmd_data   (q_push_data)
   );

   lzjb_cmd_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (lzjb_pkg::CMD_QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   lzjb_back #(
      .HISTORY_DEPTH  (HISTORY_DEPTH),
      .MATCH_LEN_BITS (MATCH_LEN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!q_empty),
      .cmd_data   (q_pop_data),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- tb/lzjb_block_decompressor_tb.sv -----
// Self-checking testbench for the LZJB block decompressor with a built-in decoder predictor.
`default_nettype none

module lzjb_block_decompressor_tb;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE = 100;
   localparam int HOLD_CYCLES = 400;
   localparam int HAW = $clog2(lzjb_pkg::HISTORY_DEPTH);

   typedef struct packed {
      logic [7:0] data;
      logic       fresh;
   } req_beat_type;

   typedef struct packed {
      logic [7:0]           lo_byte;
      logic [7:0]           hi_byte;
      logic [1:0]           count;
      lzjb_pkg::status_type status;
      logic                 last;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [lzjb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [17:0] csr_wdata = '0;

   req_beat_type pending[$];
   rsp_beat_type due_beats[$];
   logic failed = 1'b0;
   int quiet = 0;
   int send_idle = 0;
   int recv_stall = 0;
   logic hold_arm = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;
   int unsigned gen_len = 512;

   // Decoder state mirrored by the predictor.
   logic [7:0] dec_hist [lzjb_pkg::HISTORY_DEPTH];
   logic [7:0] dec_ctrl = '0;
   logic [3:0] dec_pos = lzjb_pkg::CTRL_SLOTS;
   logic [7:0] dec_high = '0;
   logic dec_wait = 1'b0;
   int unsigned dec_count = 0;
   logic dec_halt = 1'b0;
   int unsigned dec_len = 32'(lzjb_pkg::OUT_LENGTH_RESET);

   lzjb_block_decompressor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void decode_beat(input logic [7:0] b, input logic fresh);
      logic [15:0] pair;
      int unsigned span;
      int unsigned run;
      logic [7:0] v;
      logic [7:0] held;
      logic have;
      logic done;
      rsp_beat_type r;
      if (fresh) begin
         dec_ctrl = '0;
         dec_pos = lzjb_pkg::CTRL_SLOTS;
         dec_high = '0;
         dec_wait = 1'b0;
         dec_count = 0;
         dec_halt = 1'b0;
      end
      if (dec_halt || dec_count >= dec_len) return;
      if (dec_wait) begin
         pair = {dec_high, b};
         span = 32'(pair[15-lzjb_pkg::MATCH_LEN_BITS:0]);
         run = 32'(pair[15:16-lzjb_pkg::MATCH_LEN_BITS]) + 32'(lzjb_pkg::MIN_MATCH);
         dec_wait = 1'b0;
         dec_pos++;
         if (span == 0 || span > dec_count) begin
            dec_halt = 1'b1;
            due_beats.push_back('{8'h00, 8'h00, 2'd0, lzjb_pkg::STATUS_ERROR, 1'b1});
            return;
         end
         have = 1'b0;
         done = 1'b0;
         held = 8'h00;
         while (run > 0 && !done) begin
            v = dec_hist[HAW'((dec_count - span) % lzjb_pkg::HISTORY_DEPTH)];
            dec_hist[HAW'(dec_count % lzjb_pkg::HISTORY_DEPTH)] = v;
            dec_count++;
            done = (dec_count >= dec_len);
            run--;
            if (have) begin
               due_beats.push_back('{held, v, 2'd2,
                  done ? lzjb_pkg::STATUS_DONE : lzjb_pkg::STATUS_DATA, 1'b0});
               have = 1'b0;
            end else begin
               held = v;
               have = 1'b1;
            end
         end
         if (have) begin
            due_beats.push_back('{held, 8'h00, 2'd1,
               done ? lzjb_pkg::STATUS_DONE : lzjb_pkg::STATUS_DATA, 1'b0});
         end
         if (done) dec_halt = 1'b1;
         r = due_beats.pop_back();
         r.last = 1'b1;
         due_beats.push_back(r);
         return;
      end
      if (dec_pos >= lzjb_pkg::CTRL_SLOTS) begin
         dec_ctrl = b;
         dec_pos = '0;
         return;
      end
      if (dec_ctrl[dec_pos[2:0]]) begin
         dec_high = b;
         dec_wait = 1'b1;
         return;
      end
      dec_pos++;
      dec_hist[HAW'(dec_count % lzjb_pkg::HISTORY_DEPTH)] = b;
      dec_count++;
      done = (dec_count >= dec_len);
      if (done) dec_halt = 1'b1;
      due_beats.push_back('{b, 8'h00, 2'd1,
         done ? lzjb_pkg::STATUS_DONE : lzjb_pkg::STATUS_DATA, 1'b1});
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         failed = 1'b1;
      end
   endfunction

   // Sender: holds an offered beat until it is taken, otherwise idles at random.
   always @(posedge clock) begin
      logic offer_now;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) void'(pending.pop_front());
         if (req_tvalid && !req_tready) begin
            offer_now = 1'b1;
         end else begin
            offer_now = pending.size() != 0 && $urandom_range(0, 99) >= send_idle;
         end
         req_tvalid <= offer_now;
         if (offer_now) begin
            req_tdata <= pending[0].data;
            req_tuser <= pending[0].fresh;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= recv_stall;
      end
   end

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset) begin
         if (csr_we) dec_len = 32'(csr_wdata);
         if (req_tvalid && req_tready) decode_beat(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (due_beats.size() == 0) begin
               $error("unexpected result beat: tdata %0h, tuser %0d", rsp_tdata, rsp_tuser);
               failed = 1'b1;
            end else begin
               want = due_beats.pop_front();
               check_field("out_byte_first", 32'(want.lo_byte), 32'(rsp_tdata[7:0]));
               check_field("out_byte_second", 32'(want.hi_byte), 32'(rsp_tdata[15:8]));
               check_field("valid_count", 32'(want.count), 32'(rsp_tdata[17:16]));
               check_field("tdata padding", 0,
                           32'(rsp_tdata[lzjb_pkg::RSP_DATA_W-1:18]));
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("last_of_run", 32'(want.last), 32'(rsp_tlast));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic offer(input logic [7:0] data, input logic fresh);
      pending.push_back('{data, fresh});
   endtask

   task automatic drain();
      while (pending.size() != 0 || req_tvalid || due_beats.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_length(input int unsigned len);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= len[17:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      gen_len = len;
   endtask

   // Builds mostly well-formed blocks with random content, with some bad offsets,
   // abandoned blocks and stray bytes mixed in.
   task automatic make_stream(input int budget);
      int made;
      int unsigned produced;
      int top;
      int span;
      int slot;
      int extra;
      logic [5:0] len6;
      logic [7:0] ctrl;
      logic first;
      logic alive;
      made = 0;
      while (made < budget) begin
         produced = 0;
         first = 1'b1;
         alive = 1'b1;
         while (alive && made < budget) begin
            ctrl = 8'($urandom);
            if (produced == 0) ctrl[0] = 1'b0;
            offer(ctrl, first);
            first = 1'b0;
            made++;
            for (slot = 0; slot < 8 && alive; slot++) begin
               if ($urandom_range(0, 59) == 0) begin
                  alive = 1'b0;
               end else if (!ctrl[slot]) begin
                  offer(8'($urandom), 1'b0);
                  made++;
                  produced++;
               end else begin
                  if ($urandom_range(0, 3) == 0) len6 = 6'($urandom);
                  else len6 = 6'($urandom_range(0, 5));
                  top = (produced > 1023) ? 1023 : int'(produced);
                  case ($urandom_range(0, 39))
                     0: span = 0;
                     1: span = int'($urandom_range(top + 1 > 1023 ? 1023 : top + 1, 1023));
                     default: span = int'($urandom_range(1, top));
                  endcase
                  if (span == 0 || span > int'(produced)) alive = 1'b0;
                  offer({len6, 2'(span >> 8)}, 1'b0);
                  offer(8'(span), 1'b0);
                  made += 2;
                  produced += 32'(len6) + 32'(lzjb_pkg::MIN_MATCH);
               end
               if (produced >= gen_len) alive = 1'b0;
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            extra = $urandom_range(1, 3);
            repeat (extra) offer(8'($urandom), 1'b0);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Two literals, then a maximum-length match that overlaps its own output.
      offer(8'h04, 1'b1);
      offer(8'h00, 1'b0);
      offer(8'hFF, 1'b0);
      offer(8'hFC, 1'b0);
      offer(8'h02, 1'b0);
      offer(8'hA5, 1'b0);
      offer(8'h5A, 1'b0);
      offer(8'h80, 1'b0);
      offer(8'h7F, 1'b0);
      offer(8'h01, 1'b0);
      // Shortest match, a literal, then an offset reaching before the block start.
      offer(8'h05, 1'b0);
      offer(8'h00, 1'b0);
      offer(8'h01, 1'b0);
      offer(8'h33, 1'b0);
      offer(8'h03, 1'b0);
      offer(8'hFF, 1'b0);
      offer(8'h44, 1'b0);
      // Offset of zero, then a match in a block with nothing produced yet.
      offer(8'h01, 1'b1);
      offer(8'h00, 1'b0);
      offer(8'h00, 1'b0);
      offer(8'h01, 1'b1);
      offer(8'h04, 1'b0);
      offer(8'h01, 1'b0);
      make_stream(50);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin set_length(1); send_idle = 45; recv_stall = 0; end
            1: begin set_length(131072); send_idle = 0; recv_stall = 45; end
            2: begin set_length($urandom_range(2, 64)); send_idle = 18; recv_stall = 18; end
            3: begin set_length(0); send_idle = 0; recv_stall = 0; end
            4: begin set_length(2048); send_idle = 0; recv_stall = 0; hold_arm = 1'b1; end
            default: begin
               set_length($urandom_range(65, 4000));
               send_idle = 18;
               recv_stall = 18;
            end
         endcase
         make_stream(ph == 3 ? 10 : 60);
         drain();
      end

      set_length(32'(lzjb_pkg::OUT_LENGTH_RESET));
      send_idle = 45;
      recv_stall = 45;
      make_stream(20);
      drain();

      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/lzjb_pkg.sv
hdl/lzjb_front.sv
hdl/lzjb_cmd_fifo.sv
hdl/lzjb_back.sv
hdl/lzjb_block_decompressor.sv
tb/lzjb_block_decompressor_tb.sv
